>>> rtl/mcid_pkg.sv
`default_nettype none
package mcid_pkg;

  localparam int CHANNELS   = 16;
  localparam int GAP_W      = 10;
  localparam int LIMIT_W    = 8;
  localparam int LEVELS_W   = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [GAP_W-1:0]    GAP_RESET   = GAP_W'(10);
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET = LIMIT_W'(3);
  localparam logic [LEVELS_W-1:0] IDLE_RESET  = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCAN_GAP       = 2'd0,
    REG_DEBOUNCE_LIMIT = 2'd1,
    REG_IDLE_LEVELS    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic               scan;
    logic [LIMIT_W-1:0] limit;
  } scan_ctl_t;

endpackage
`default_nettype wire

>>> rtl/mcid_scan.sv
`default_nettype none
module mcid_scan
  import mcid_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire scan_ctl_t           ctl,
  input  wire logic [CHANNELS-1:0] raw,
  output logic      [CHANNELS-1:0] stable_nxt
);

  logic [CHANNELS-1:0] stable_r;
  logic [CHANNELS-1:0] cand_r;
  logic [CHANNELS-1:0] cand_nxt;
  logic [LIMIT_W-1:0]  cnt_r   [CHANNELS];
  logic [LIMIT_W-1:0]  cnt_nxt [CHANNELS];

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      stable_nxt[i] = stable_r[i];
      cand_nxt[i]   = cand_r[i];
      cnt_nxt[i]    = cnt_r[i];
      if (ctl.scan && (raw[i] != stable_r[i])) begin
        if (raw[i] == cand_r[i]) begin
          // count up to the limit, then take the new level on a later scan
          if (cnt_r[i] < ctl.limit) begin
            cnt_nxt[i] = cnt_r[i] + LIMIT_W'(1);
          end else begin
            stable_nxt[i] = raw[i];
          end
        end else begin
          cand_nxt[i] = raw[i];
          cnt_nxt[i]  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= IDLE_RESET[CHANNELS-1:0];
      cand_r   <= IDLE_RESET[CHANNELS-1:0];
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (adv) begin
      stable_r <= stable_nxt;
      cand_r   <= cand_nxt;
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/multi_channel_input_debouncer_top.sv
// Multi-channel input debouncer.
// Input channel (in_valid/in_ready): one transaction per system tick, carrying
// the raw levels of all 16 pins. A tick prescaler triggers a scan every
// scan_gap ticks; on a scan every channel runs its own debounce counter.
// Output channel (out_valid/out_ready): one transaction per input, carrying
// the active flags (stable level differs from idle), the run mode of channel 0,
// a pulse when the run mode changed and a flag for ticks that scanned.
// out_valid rises in the cycle after input acceptance. Throughput is one
// tick per cycle while the receiver takes results; the per-channel compare and count update is the only logic
// between the input handshake and the result register.
// If the receiver stalls, the result register holds and in_ready stays high
// only in the cycle where the held result is taken, so nothing is dropped.
// Configuration (cfg_valid/cfg_ready, always ready): index 0 scan_gap,
// 1 debounce_limit, 2 idle_levels; other indexes are ignored.
// Reset: scan_gap 10, debounce_limit 3, idle levels 0, stable and candidate
// levels at idle, counts and prescaler cleared, no previous run mode.
`default_nettype none
module multi_channel_input_debouncer_top
  import mcid_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [LEVELS_W-1:0]  in_raw_levels,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [LEVELS_W-1:0]  out_active_levels,
  output logic                      out_run_active,
  output logic                      out_mode_toggle,
  output logic                      out_scan_done,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LEVELS_W-1:0]  cfg_data
);

  logic [GAP_W-1:0]    gap_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic [LEVELS_W-1:0] idle_r;
  logic [GAP_W-1:0]    tick_r;
  logic [GAP_W-1:0]    tick_inc;
  logic [GAP_W-1:0]    tick_nxt;
  logic                last_mode_r;
  logic                last_valid_r;
  logic                adv;
  logic                scan;
  logic                run;
  logic [CHANNELS-1:0] stable_nxt;
  logic [CHANNELS-1:0] active;
  scan_ctl_t           ctl;

  logic                out_valid_r;
  logic [LEVELS_W-1:0] active_r;
  logic                run_r;
  logic                switched_r;
  logic                scan_done_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign adv       = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r   <= GAP_RESET;
      limit_r <= LIMIT_RESET;
      idle_r  <= IDLE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCAN_GAP:       gap_r   <= cfg_data[GAP_W-1:0];
        REG_DEBOUNCE_LIMIT: limit_r <= cfg_data[LIMIT_W-1:0];
        REG_IDLE_LEVELS:    idle_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // prescaler: wrap at the gap and scan on that tick
  always_comb begin
    tick_inc = tick_r + GAP_W'(1);
    scan     = (tick_inc >= gap_r);
    tick_nxt = scan ? '0 : tick_inc;
  end

  assign ctl.scan  = scan;
  assign ctl.limit = limit_r;

  mcid_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .ctl        (ctl),
    .raw        (in_raw_levels[CHANNELS-1:0]),
    .stable_nxt (stable_nxt)
  );

  assign active = stable_nxt ^ idle_r[CHANNELS-1:0];
  assign run    = active[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r       <= '0;
      last_mode_r  <= 1'b0;
      last_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (adv) begin
        tick_r       <= tick_nxt;
        last_mode_r  <= run;
        last_valid_r <= 1'b1;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      active_r    <= LEVELS_W'(active);
      run_r       <= run;
      switched_r  <= last_valid_r && (run != last_mode_r);
      scan_done_r <= scan;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_active_levels = active_r;
  assign out_run_active    = run_r;
  assign out_mode_toggle   = switched_r;
  assign out_scan_done     = scan_done_r;

endmodule
`default_nettype wire

>>> verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mcid_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 3;
  // index 3 maps to no register; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [LEVELS_W-1:0] active;
    logic                run;
    logic                switched;
    logic                scanned;
  } status_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic [LEVELS_W-1:0]  in_raw_levels = '0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic [LEVELS_W-1:0]  out_active_levels;
  logic                 out_run_active;
  logic                 out_mode_toggle;
  logic                 out_scan_done;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [LEVELS_W-1:0]  cfg_data      = '0;

  multi_channel_input_debouncer_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_raw_levels     (in_raw_levels),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_active_levels (out_active_levels),
    .out_run_active    (out_run_active),
    .out_mode_toggle   (out_mode_toggle),
    .out_scan_done     (out_scan_done),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Debouncer state mirror, starting at reset values
  logic [GAP_W-1:0]    gap_reg    = GAP_RESET;
  logic [LIMIT_W-1:0]  limit_reg  = LIMIT_RESET;
  logic [LEVELS_W-1:0] idle_reg   = IDLE_RESET;
  logic [GAP_W-1:0]    tick_cnt   = '0;
  logic [LEVELS_W-1:0] stable_lvl = IDLE_RESET;
  logic [LEVELS_W-1:0] cand_lvl   = IDLE_RESET;
  logic [LIMIT_W-1:0]  settle_cnt [CHANNELS];
  logic                last_mode  = 1'b0;
  logic                mode_seen  = 1'b0;

  logic [LEVELS_W-1:0] tick_q [$];
  status_t             expected_status_q [$];

  int  ticks_queued   = 0;
  int  ticks_accepted = 0;
  int  status_checked = 0;
  int  cfg_writes     = 0;
  int  error_count    = 0;
  int  scan_count     = 0;
  int  switch_count   = 0;
  int  settings_count = 0;
  int  quiet_cycles   = 0;
  logic in_taken      = 1'b0;

  initial begin
    for (int i = 0; i < CHANNELS; i++) settle_cnt[i] = '0;
  end

  function automatic status_t debounce_tick(input logic [LEVELS_W-1:0] raw);
    status_t s;
    s = '0;
    tick_cnt = tick_cnt + GAP_W'(1);
    if (tick_cnt >= gap_reg) begin
      tick_cnt  = '0;
      s.scanned = 1'b1;
      for (int i = 0; i < CHANNELS; i++) begin
        if (raw[i] != stable_lvl[i]) begin
          if (raw[i] == cand_lvl[i]) begin
            // count up to the limit, take the level on the scan after
            if (settle_cnt[i] < limit_reg) settle_cnt[i] = settle_cnt[i] + LIMIT_W'(1);
            else stable_lvl[i] = raw[i];
          end else begin
            cand_lvl[i]   = raw[i];
            settle_cnt[i] = '0;
          end
        end
      end
    end
    s.active   = stable_lvl ^ idle_reg;
    s.run      = s.active[0];
    s.switched = mode_seen && (s.run != last_mode);
    last_mode  = s.run;
    mode_seen  = 1'b1;
    return s;
  endfunction

  // Idling schedule: receiver-heavy, then sender-heavy, then none
  function automatic int send_gap_pct();
    if (ticks_accepted < 620) return 30;
    else if (ticks_accepted < 1240) return 85;
    else return 0;
  endfunction

  function automatic int recv_stall_pct();
    if (ticks_accepted < 620) return 85;
    else if (ticks_accepted < 1240) return 30;
    else return 0;
  endfunction

  // Driver: hold an unaccepted transaction, otherwise maybe launch the next
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct()) begin
      in_valid      <= 1'b1;
      in_raw_levels <= tick_q.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct());
  end

  // Monitor: check results first, then predict for the accepted tick
  always @(posedge clk) begin
    status_t got;
    status_t exp_s;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_active_levels, out_run_active, out_mode_toggle, out_scan_done};
        if (expected_status_q.size() == 0) begin
          $display("%0t: unexpected result active=%h run=%b switched=%b scan=%b",
                   $time, got.active, got.run, got.switched, got.scanned);
          error_count++;
        end else begin
          exp_s = expected_status_q.pop_front();
          if (got.active !== exp_s.active) begin
            $display("%0t: active_levels expected %h actual %h",
                     $time, exp_s.active, got.active);
            error_count++;
          end
          if (got.run !== exp_s.run) begin
            $display("%0t: run_active expected %b actual %b", $time, exp_s.run, got.run);
            error_count++;
          end
          if (got.switched !== exp_s.switched) begin
            $display("%0t: mode_toggle expected %b actual %b",
                     $time, exp_s.switched, got.switched);
            error_count++;
          end
          if (got.scanned !== exp_s.scanned) begin
            $display("%0t: scan_done expected %b actual %b",
                     $time, exp_s.scanned, got.scanned);
            error_count++;
          end
        end
        if (got.scanned === 1'b1) scan_count++;
        if (got.switched === 1'b1) switch_count++;
        status_checked++;
      end
      if (in_valid && in_ready) begin
        expected_status_q.push_back(debounce_tick(in_raw_levels));
        ticks_accepted++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_SCAN_GAP:       gap_reg   = cfg_data[GAP_W-1:0];
          REG_DEBOUNCE_LIMIT: limit_reg = cfg_data[LIMIT_W-1:0];
          REG_IDLE_LEVELS:    idle_reg  = cfg_data;
          default: ;
        endcase
        cfg_writes++;
      end
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    wait (ticks_accepted == ticks_queued && status_checked == ticks_accepted);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LEVELS_W-1:0] data);
    int start;
    start = cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    wait (cfg_writes != start);
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_tick(input logic [LEVELS_W-1:0] raw);
    tick_q.push_back(raw);
    ticks_queued++;
  endtask

  task automatic apply_setting(input logic [GAP_W-1:0] gap, input logic [LIMIT_W-1:0] lim,
                               input logic [LEVELS_W-1:0] idle);
    wait_drained();
    cfg_write(REG_SCAN_GAP, LEVELS_W'(gap));
    cfg_write(REG_DEBOUNCE_LIMIT, LEVELS_W'(lim));
    cfg_write(REG_IDLE_LEVELS, idle);
    cfg_release();
    settings_count++;
  endtask

  // Pins held at a target level that moves now and then, with bounce on top
  task automatic random_phase(input logic [GAP_W-1:0] gap, input logic [LIMIT_W-1:0] lim,
                              input logic [LEVELS_W-1:0] idle, input int n,
                              input int hold, input bit noisy);
    logic [LEVELS_W-1:0] target;
    logic [LEVELS_W-1:0] raw;
    apply_setting(gap, lim, idle);
    target = LEVELS_W'($urandom);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, hold - 1) == 0) begin
        if ($urandom_range(0, 1) == 1) target = LEVELS_W'($urandom);
        else target = target ^ (LEVELS_W'(1) << $urandom_range(0, LEVELS_W - 1));
      end
      raw = target;
      if (noisy) begin
        if ($urandom_range(0, 9) == 0) raw = LEVELS_W'($urandom);
        else if ($urandom_range(0, 5) == 0) raw = raw ^ LEVELS_W'($urandom & $urandom & $urandom);
      end
      add_tick(raw);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset setting; first tick must not pulse the mode toggle
    add_tick(16'h0000);
    add_tick(16'hFFFF);
    add_tick(16'hFFFF);
    add_tick(16'h0001);
    settings_count++;

    // scan every tick, take a level on its first repeat
    apply_setting('0, '0, '0);
    add_tick(16'hFFFF);
    add_tick(16'hFFFF);
    add_tick(16'h0000);
    add_tick(16'h0000);
    add_tick(16'hAAAA);
    add_tick(16'hAAAA);
    add_tick(16'h5555);
    add_tick(16'h5555);
    add_tick(16'h0001);
    add_tick(16'h0001);

    // new idle levels only change the active compare; unmapped index ignored
    wait_drained();
    cfg_write(REG_IDLE_LEVELS, 16'hFFFF);
    cfg_write(REG_UNMAPPED, 16'hFFFF);
    cfg_release();
    settings_count++;
    add_tick(16'h0000);
    add_tick(16'h0000);
    add_tick(16'hFFFF);
    add_tick(16'h7FFE);
    add_tick(16'h7FFE);

    random_phase(10'd2, 8'd1, LEVELS_W'($urandom), 250, 16, 1'b1);
    random_phase(10'd0, 8'd255, LEVELS_W'($urandom), 300, 400, 1'b0);
    random_phase(10'd1023, 8'd0, 16'hFFFF, 1040, 300, 1'b1);
    random_phase(10'd3, 8'd2, LEVELS_W'($urandom), 150, 30, 1'b1);
    random_phase(10'd1, 8'd4, 16'h0000, 100, 25, 1'b1);

    wait_drained();
    repeat (5) @(posedge clk);
    if (expected_status_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_status_q.size());
      error_count++;
    end
    $display("Checked %0d ticks over %0d debounce settings (scan gap 0..1023, limit 0..255).",
             status_checked, settings_count);
    $display("Observed %0d scans and %0d run-mode changes.", scan_count, switch_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
